// ===== sv/mlc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and code tables for the Morse letter codec.
// Used by every module of the codec; depends on nothing.

package mlc_pkg;

	localparam int MAX_CODE_LEN = 4;
	localparam int MAX_RESULTS  = 5;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int TREE_SIZE    = 30;

	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] STAR_BYTE  = 8'h2A;

	localparam logic [2:0] CFG_DIRECTION    = 3'd0;
	localparam logic [2:0] CFG_SHORT_CHAR   = 3'd1;
	localparam logic [2:0] CFG_LONG_CHAR    = 3'd2;
	localparam logic [2:0] CFG_GAP_CHAR     = 3'd3;
	localparam logic [2:0] CFG_WORD_GAP_LEN = 3'd4;

	localparam logic [7:0] TREE_ROWS [TREE_SIZE] = '{
		"e", "t",
		"i", "a", "n", "m",
		"s", "u", "r", "w", "d", "k", "g", "o",
		"h", "v", "f", "*", "l", "*", "p", "j",
		"b", "x", "c", "y", "z", "q", "*", "*"
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       bad;
	} res_t;

	typedef struct packed {
		logic [2:0]                   count;
		res_t [MAX_RESULTS-1:0]       res;
	} job_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] len;
		logic [3:0] bits;
	} enc_t;

	function automatic enc_t letter_code(input logic [7:0] c);
		enc_t e;
		e = '{valid: 1'b1, len: 3'd0, bits: 4'd0};
		case (c)
			"e": begin e.len = 3'd1; e.bits = 4'b0000; end
			"t": begin e.len = 3'd1; e.bits = 4'b0001; end
			"i": begin e.len = 3'd2; e.bits = 4'b0000; end
			"a": begin e.len = 3'd2; e.bits = 4'b0001; end
			"n": begin e.len = 3'd2; e.bits = 4'b0010; end
			"m": begin e.len = 3'd2; e.bits = 4'b0011; end
			"s": begin e.len = 3'd3; e.bits = 4'b0000; end
			"u": begin e.len = 3'd3; e.bits = 4'b0001; end
			"r": begin e.len = 3'd3; e.bits = 4'b0010; end
			"w": begin e.len = 3'd3; e.bits = 4'b0011; end
			"d": begin e.len = 3'd3; e.bits = 4'b0100; end
			"k": begin e.len = 3'd3; e.bits = 4'b0101; end
			"g": begin e.len = 3'd3; e.bits = 4'b0110; end
			"o": begin e.len = 3'd3; e.bits = 4'b0111; end
			"h": begin e.len = 3'd4; e.bits = 4'b0000; end
			"v": begin e.len = 3'd4; e.bits = 4'b0001; end
			"f": begin e.len = 3'd4; e.bits = 4'b0010; end
			"l": begin e.len = 3'd4; e.bits = 4'b0100; end
			"p": begin e.len = 3'd4; e.bits = 4'b0110; end
			"j": begin e.len = 3'd4; e.bits = 4'b0111; end
			"b": begin e.len = 3'd4; e.bits = 4'b1000; end
			"x": begin e.len = 3'd4; e.bits = 4'b1001; end
			"c": begin e.len = 3'd4; e.bits = 4'b1010; end
			"y": begin e.len = 3'd4; e.bits = 4'b1011; end
			"z": begin e.len = 3'd4; e.bits = 4'b1100; end
			"q": begin e.len = 3'd4; e.bits = 4'b1101; end
			default: e.valid = 1'b0;
		endcase
		return e;
	endfunction

	function automatic res_t decode_letter(input logic [2:0] len, input logic [3:0] bits);
		res_t       r;
		logic [4:0] base;
		logic [4:0] pos;
		logic [3:0] mask;
		r    = '{ch: STAR_BYTE, bad: 1'b1};
		base = 5'((5'd1 << len) - 5'd2);
		mask = 4'((5'd1 << len) - 5'd1);
		pos  = base + {1'b0, bits & mask};
		if (len >= 3'd1 && len <= 3'(MAX_CODE_LEN) && pos < 5'(TREE_SIZE)) begin
			if (TREE_ROWS[pos] != STAR_BYTE) begin
				r.ch  = TREE_ROWS[pos];
				r.bad = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/mlc_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, input acceptance, decode state and
// construction of the result list for each beat. Depends on mlc_pkg.

module mlc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_in,
	input  logic                end_of_text,
	output logic                push_valid,
	input  logic                push_ready,
	output mlc_pkg::job_t       push_job
);

	logic       direction_q;
	logic [7:0] short_char_q;
	logic [7:0] long_char_q;
	logic [7:0] gap_char_q;
	logic [2:0] word_gap_len_q;

	logic [3:0] code_bits_q,   code_bits_d;
	logic [2:0] code_length_q, code_length_d;
	logic [2:0] gap_count_q,   gap_count_d;
	logic       letter_seen_q, letter_seen_d;

	mlc_pkg::job_t job;
	logic          accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = push_ready;
	assign accept    = in_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q    <= 1'b0;
			short_char_q   <= 8'd46;
			long_char_q    <= 8'd45;
			gap_char_q     <= 8'd32;
			word_gap_len_q <= 3'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				mlc_pkg::CFG_DIRECTION:    direction_q    <= cfg_data[0];
				mlc_pkg::CFG_SHORT_CHAR:   short_char_q   <= cfg_data;
				mlc_pkg::CFG_LONG_CHAR:    long_char_q    <= cfg_data;
				mlc_pkg::CFG_GAP_CHAR:     gap_char_q     <= cfg_data;
				mlc_pkg::CFG_WORD_GAP_LEN: word_gap_len_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		mlc_pkg::enc_t enc;
		logic [3:0]    sym;
		logic [2:0]    n;
		logic [2:0]    limit;
		logic [2:0]    gcn;
		job           = '0;
		code_bits_d   = code_bits_q;
		code_length_d = code_length_q;
		gap_count_d   = gap_count_q;
		letter_seen_d = letter_seen_q;
		n             = 3'd0;
		enc           = mlc_pkg::letter_code(char_in);
		sym           = 4'(enc.bits << (3'd4 - enc.len));
		limit         = (word_gap_len_q == 3'd0) ? 3'd1 : word_gap_len_q;
		gcn           = gap_count_q;
		if (!direction_q) begin
			if (char_in == mlc_pkg::SPACE_BYTE) begin
				job.res[0] = '{ch: gap_char_q, bad: 1'b0};
				job.res[1] = '{ch: gap_char_q, bad: 1'b0};
				n          = 3'd2;
			end else if (enc.valid) begin
				for (int k = 0; k < mlc_pkg::MAX_RESULTS; k++) begin
					if (3'(k) < enc.len) begin
						job.res[k] = '{ch: sym[3-k] ? long_char_q : short_char_q, bad: 1'b0};
					end else if (3'(k) == enc.len) begin
						job.res[k] = '{ch: gap_char_q, bad: 1'b0};
					end
				end
				n = enc.len + 3'd1;
			end
		end else begin
			if (char_in == gap_char_q) begin
				if (letter_seen_q) begin
					job.res[0]    = mlc_pkg::decode_letter(code_length_q, code_bits_q);
					n             = 3'd1;
					code_bits_d   = 4'd0;
					code_length_d = 3'd0;
					letter_seen_d = 1'b0;
				end
				if (gap_count_q != 3'd7) begin
					gcn = gap_count_q + 3'd1;
				end
				if (gcn >= limit) begin
					job.res[n] = '{ch: mlc_pkg::SPACE_BYTE, bad: 1'b0};
					n          = n + 3'd1;
					gcn        = 3'd0;
				end
				gap_count_d = gcn;
			end else if (char_in == long_char_q || char_in == short_char_q) begin
				gap_count_d   = 3'd0;
				letter_seen_d = 1'b1;
				if (code_length_q < 3'(mlc_pkg::MAX_CODE_LEN)) begin
					code_bits_d = {code_bits_q[2:0], char_in == long_char_q};
				end
				if (code_length_q <= 3'(mlc_pkg::MAX_CODE_LEN)) begin
					code_length_d = code_length_q + 3'd1;
				end
			end
			if (end_of_text) begin
				if (letter_seen_d) begin
					job.res[n] = mlc_pkg::decode_letter(code_length_d, code_bits_d);
					n          = n + 3'd1;
				end
				code_bits_d   = 4'd0;
				code_length_d = 3'd0;
				letter_seen_d = 1'b0;
				gap_count_d   = 3'd0;
			end
		end
		job.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bits_q   <= 4'd0;
			code_length_q <= 3'd0;
			gap_count_q   <= 3'd0;
			letter_seen_q <= 1'b0;
		end else if (accept && direction_q) begin
			code_bits_q   <= code_bits_d;
			code_length_q <= code_length_d;
			gap_count_q   <= gap_count_d;
			letter_seen_q <= letter_seen_d;
		end
	end

	assign push_valid = in_valid && (job.count != 3'd0);
	assign push_job   = job;

endmodule

// ===== sv/mlc_job_queue.sv =====
`timescale 1ns / 1ps
// Short queue of result lists between the front end and the serialiser.
// Depends on mlc_pkg for the job type and the queue depth.

module mlc_job_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  mlc_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output mlc_pkg::job_t pop_job
);

	mlc_pkg::job_t                   entry_q [mlc_pkg::QUEUE_DEPTH];
	logic [mlc_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [mlc_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [mlc_pkg::QPTR_W:0]        fill_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (fill_q != (mlc_pkg::QPTR_W+1)'(mlc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == mlc_pkg::QPTR_W'(mlc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == mlc_pkg::QPTR_W'(mlc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/mlc_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the result list at the head of the queue, one result per
// beat, into the output register. Depends on mlc_pkg.

module mlc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  mlc_pkg::job_t pop_job,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    char_out,
	output logic          last_of_run,
	output logic          bad_code
);

	logic [2:0]    idx_q;
	logic          out_valid_q;
	logic [7:0]    char_q;
	logic          last_q;
	logic          bad_q;
	logic          emit;
	logic          is_last;
	mlc_pkg::res_t cur;

	assign emit      = pop_valid && (!out_valid_q || out_ready);
	assign is_last   = (idx_q == pop_job.count - 3'd1);
	assign cur       = pop_job.res[idx_q];
	assign pop_ready = emit && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= cur.ch;
			bad_q  <= cur.bad;
			last_q <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign char_out    = char_q;
	assign last_of_run = last_q;
	assign bad_code    = bad_q;

	a_job_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> (pop_job.count != 3'd0 && pop_job.count <= 3'(mlc_pkg::MAX_RESULTS)))
		else $error("queued result list has an invalid length");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> (idx_q < pop_job.count))
		else $error("result index beyond the end of the list");

	a_last_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && is_last) |=> (out_valid_q && last_q && idx_q == 3'd0))
		else $error("final result of a list not flagged as last");

endmodule

// ===== sv/morse_letter_codec.sv =====
`timescale 1ns / 1ps
// Top level of the Morse letter codec: front end, job queue and back end.
// Depends on mlc_pkg, mlc_front, mlc_job_queue and mlc_back.

// The front end takes one input beat per cycle whenever the two-entry job
// queue has room, updates the decode state and turns the byte into a list of
// up to five results; the back end sends them out one per cycle while
// out_ready allows, through a registered output. Each item yields as many
// output beats as it has results: up to five for a four-symbol letter in
// encode mode, at most two in decode mode, none for an ignored byte. Results
// pass through a queue entry and then the output register. Configuration
// writes are always taken and must only be issued while the block is idle.

module morse_letter_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_out,
	output logic       last_of_run,
	output logic       bad_code
);

	logic          push_valid;
	logic          push_ready;
	mlc_pkg::job_t push_job;
	logic          pop_valid;
	logic          pop_ready;
	mlc_pkg::job_t pop_job;

	mlc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_in     (char_in),
		.end_of_text (end_of_text),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_job    (push_job)
	);

	mlc_job_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	mlc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_job     (pop_job),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_out    (char_out),
		.last_of_run (last_of_run),
		.bad_code    (bad_code)
	);

endmodule
